@@ design/rgb24_rotate_flip_addr_gen_top_macros.svh @@
// assertion macros shared by the rotate/flip address generator rtl
// no dependencies; included by the modules that carry checks
`ifndef RGB24_ROTATE_FLIP_ADDR_GEN_TOP_MACROS_SVH
`define RGB24_ROTATE_FLIP_ADDR_GEN_TOP_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define RRFAG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rrfag assertion failed");

// condition in a cycle implies a consequence in the next cycle
`define RRFAG_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("rrfag assertion failed");

`else

`define RRFAG_ASSERT(label, clk, rst_n, prop)
`define RRFAG_ASSERT_NEXT(label, clk, rst_n, cond, nxt)

`endif

`endif

@@ design/rrfag_pkg.sv @@
// shared types and constants of the rotate/flip address generator
// no dependencies; used by every rtl module of the block
`timescale 1ns / 1ps

package rrfag_pkg;

    // configuration register widths and indexes
    localparam int MODE_W   = 3;
    localparam int DIM_CFG_W = 13;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    // reset values of the registers
    localparam logic [MODE_W-1:0]    MODE_RST   = 3'd0;
    localparam logic [DIM_CFG_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [DIM_CFG_W-1:0] HEIGHT_RST = 13'd480;

    // payload widths
    localparam int COLOR_W = 8;
    localparam int RGB_W   = 3 * COLOR_W;
    localparam int IDX_W   = 24;

    // depth of the queue between front and back
    localparam int QDEPTH = 4;

    // mapping modes; the unused code behaves as copy
    typedef enum logic [MODE_W-1:0] {
        MODE_COPY     = 3'd0,
        MODE_ROT90    = 3'd1,
        MODE_ROT180   = 3'd2,
        MODE_ROT270   = 3'd3,
        MODE_FLIP_V   = 3'd4,
        MODE_FLIP_H   = 3'd5,
        MODE_FLIP_AD  = 3'd6
    } t_mode;

endpackage

@@ design/rrfag_front.sv @@
// front end: configuration registers, column/row counters and operand selection
// depends on rrfag_pkg; feeds rrfag_queue
`timescale 1ns / 1ps
`include "rgb24_rotate_flip_addr_gen_top_macros.svh"

module rrfag_front #(
    parameter int MAX_DIM = 4096,
    parameter int CW      = $clog2(MAX_DIM),
    parameter int DW      = $clog2(MAX_DIM + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [rrfag_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rrfag_pkg::CFG_W-1:0]    i_cfg_data,
    // pixel transfer from the source side
    input  logic                           i_push,
    // operands of index = a * b + c
    output logic [DW-1:0]                  o_op_a,
    output logic [DW-1:0]                  o_op_b,
    output logic [DW-1:0]                  o_op_c,
    output logic                           o_last
);

    logic [rrfag_pkg::MODE_W-1:0]    r_mode;
    logic [rrfag_pkg::DIM_CFG_W-1:0] r_frame_width;
    logic [rrfag_pkg::DIM_CFG_W-1:0] r_frame_height;
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;

    logic [DW-1:0] w, h, x, y;
    logic [DW-1:0] w_m1_x, h_m1_y;
    logic          x_end, y_end, outside;

    // clamp a configured size into 1..MAX_DIM
    function automatic logic [DW-1:0] eff_dim(input logic [rrfag_pkg::DIM_CFG_W-1:0] v);
        logic [DW-1:0] res;
        if (v == '0) begin
            res = DW'(1);
        end else if (32'(v) > 32'(MAX_DIM)) begin
            res = DW'(MAX_DIM);
        end else begin
            res = DW'(v);
        end
        return res;
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= rrfag_pkg::MODE_RST;
            r_frame_width  <= rrfag_pkg::WIDTH_RST;
            r_frame_height <= rrfag_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rrfag_pkg::REG_MODE: begin
                    r_mode <= i_cfg_data[rrfag_pkg::MODE_W-1:0];
                end
                rrfag_pkg::REG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[rrfag_pkg::DIM_CFG_W-1:0];
                end
                rrfag_pkg::REG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[rrfag_pkg::DIM_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // current position, restarted when a size change left the counters outside
    always_comb begin
        w       = eff_dim(r_frame_width);
        h       = eff_dim(r_frame_height);
        outside = (DW'(r_col) >= w) || (DW'(r_row) >= h);
        x       = outside ? '0 : DW'(r_col);
        y       = outside ? '0 : DW'(r_row);
        w_m1_x  = w - DW'(1) - x;
        h_m1_y  = h - DW'(1) - y;
        x_end   = (x == w - DW'(1));
        y_end   = (y == h - DW'(1));
        o_last  = x_end && y_end;
    end

    // operand selection per mode
    always_comb begin
        case (r_mode)
            rrfag_pkg::MODE_ROT90: begin
                o_op_a = w_m1_x; o_op_b = h; o_op_c = y;
            end
            rrfag_pkg::MODE_ROT180: begin
                o_op_a = h_m1_y; o_op_b = w; o_op_c = w_m1_x;
            end
            rrfag_pkg::MODE_ROT270: begin
                o_op_a = x;      o_op_b = h; o_op_c = h_m1_y;
            end
            rrfag_pkg::MODE_FLIP_V: begin
                o_op_a = h_m1_y; o_op_b = w; o_op_c = x;
            end
            rrfag_pkg::MODE_FLIP_H: begin
                o_op_a = y;      o_op_b = w; o_op_c = w_m1_x;
            end
            rrfag_pkg::MODE_FLIP_AD: begin
                o_op_a = w_m1_x; o_op_b = h; o_op_c = h_m1_y;
            end
            default: begin
                o_op_a = y;      o_op_b = w; o_op_c = x;
            end
        endcase
    end

    // raster advance
    always_comb begin
        if (x_end) begin
            n_col = '0;
            n_row = y_end ? '0 : CW'(y + DW'(1));
        end else begin
            n_col = CW'(x + DW'(1));
            n_row = CW'(y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    `RRFAG_ASSERT_NEXT(a_frame_wrap, i_clk, i_rst_n, i_push && o_last,
        r_col == '0 && r_row == '0)

endmodule

@@ design/rrfag_queue.sv @@
// short register queue that decouples the front end from the back end
// depends on rrfag_pkg for its depth
`timescale 1ns / 1ps
`include "rgb24_rotate_flip_addr_gen_top_macros.svh"

module rrfag_queue #(
    parameter int DATA_W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data
);

    localparam int PW = $clog2(rrfag_pkg::QDEPTH);
    localparam int NW = $clog2(rrfag_pkg::QDEPTH + 1);

    logic [DATA_W-1:0] r_mem [rrfag_pkg::QDEPTH];
    logic [PW-1:0]     r_wr_ptr;
    logic [PW-1:0]     r_rd_ptr;
    logic [NW-1:0]     r_count, n_count;

    assign o_full  = (r_count == NW'(rrfag_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // storage, written on each push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + NW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= n_count;
        end
    end

    `RRFAG_ASSERT(a_no_overflow, i_clk, i_rst_n, o_full |-> !i_push)
    `RRFAG_ASSERT(a_no_underflow, i_clk, i_rst_n, !o_valid |-> !i_pop)

endmodule

@@ design/rrfag_back.sv @@
// back end: multiply stage, add stage and output register of the index
// depends on rrfag_pkg; drains rrfag_queue
`timescale 1ns / 1ps
`include "rgb24_rotate_flip_addr_gen_top_macros.svh"

module rrfag_back #(
    parameter int DW = 13
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // entry from the queue
    input  logic                        i_valid,
    output logic                        o_pop,
    input  logic [DW-1:0]               i_op_a,
    input  logic [DW-1:0]               i_op_b,
    input  logic [DW-1:0]               i_op_c,
    input  logic [rrfag_pkg::RGB_W-1:0] i_rgb,
    input  logic                        i_last,
    // result side
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [rrfag_pkg::IDX_W-1:0] o_index,
    output logic [rrfag_pkg::RGB_W-1:0] o_rgb,
    output logic                        o_last
);

    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    logic                        r_s1_valid;
    logic [PW-1:0]               r_s1_prod;
    logic [DW-1:0]               r_s1_c;
    logic [rrfag_pkg::RGB_W-1:0] r_s1_rgb;
    logic                        r_s1_last;

    logic                        r_out_valid;
    logic [rrfag_pkg::IDX_W-1:0] r_out_index;
    logic [rrfag_pkg::RGB_W-1:0] r_out_rgb;
    logic                        r_out_last;

    logic                        out_ready;
    logic                        s1_ready;
    logic [SW-1:0]               sum;

    // stall chain: a stage loads when it is empty or its content moves on
    assign out_ready = !r_out_valid || i_ready;
    assign s1_ready  = !r_s1_valid || out_ready;
    assign o_pop     = i_valid && s1_ready;

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_prod <= i_op_a * i_op_b;
            r_s1_c    <= i_op_c;
            r_s1_rgb  <= i_rgb;
            r_s1_last <= i_last;
        end
    end

    // add stage into the output register, index kept to its low bits
    assign sum = SW'(r_s1_prod) + SW'(r_s1_c);

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && out_ready) begin
            r_out_index <= rrfag_pkg::IDX_W'(sum);
            r_out_rgb   <= r_s1_rgb;
            r_out_last  <= r_s1_last;
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= o_pop;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_index = r_out_index;
    assign o_rgb   = r_out_rgb;
    assign o_last  = r_out_last;

    `RRFAG_ASSERT_NEXT(a_pop_fills_s1, i_clk, i_rst_n, o_pop, r_s1_valid)

endmodule

@@ design/rgb24_rotate_flip_addr_gen_top.sv @@
// top level of the rgb24 rotate/flip destination address generator
// depends on rrfag_pkg, rrfag_front, rrfag_queue and rrfag_back
`timescale 1ns / 1ps

// Source pixels enter on the s_ stream in raster order, one per transfer.
// Each pixel leaves on the m_ stream with its destination pixel index in the
// output frame for the selected rotate/flip mode, the colour bytes unchanged,
// and m_tlast set on the last pixel of the source frame.
// Registers (mode, frame width, frame height) are written through the
// i_cfg_ port; the user must write them only while no pixel is in flight,
// which the block itself does not enforce. Sizes are clamped to 1..MAX_DIM.
// Throughput is one pixel per clock while m_tready is high. Each pixel is
// written into a four-entry queue, multiplied into the multiply stage
// register and summed into the output register that drives m_tvalid.
// When the receiver holds m_tready low the output register and the multiply
// stage hold, the queue fills, and s_tready falls once four pixels wait.
// Reset restores mode copy, 640 x 480 and clears the column and row
// counters; the next pixel is then x = 0, y = 0. A size change that leaves
// the counters outside the frame starts a new frame at the next pixel.

module rgb24_rotate_flip_addr_gen_top #(
    parameter int MAX_DIM = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [rrfag_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rrfag_pkg::CFG_W-1:0]     i_cfg_data,
    // source pixels
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // red_in, green_in, blue_in
    // destination indexes
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [47:0]                     m_tdata,   // red_out, green_out, blue_out, dest_index
    output logic                            m_tlast    // frame_last
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int QW = 3 * DW + rrfag_pkg::RGB_W + 1;

    logic          push;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    logic [QW-1:0] q_wdata;
    logic [QW-1:0] q_rdata;

    logic [DW-1:0] f_op_a, f_op_b, f_op_c;
    logic          f_last;

    logic [rrfag_pkg::IDX_W-1:0] b_index;
    logic [rrfag_pkg::RGB_W-1:0] b_rgb;

    // source transfer
    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    rrfag_front #(
        .MAX_DIM (MAX_DIM),
        .CW      (CW),
        .DW      (DW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .o_op_a      (f_op_a),
        .o_op_b      (f_op_b),
        .o_op_c      (f_op_c),
        .o_last      (f_last)
    );

    // queue entry: last flag, colour bytes, c, b, a from the top down
    assign q_wdata = {f_last, s_tdata, f_op_c, f_op_b, f_op_a};

    rrfag_queue #(
        .DATA_W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    rrfag_back #(
        .DW (DW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (q_pop),
        .i_op_a  (q_rdata[DW-1:0]),
        .i_op_b  (q_rdata[2*DW-1:DW]),
        .i_op_c  (q_rdata[3*DW-1:2*DW]),
        .i_rgb   (q_rdata[3*DW+rrfag_pkg::RGB_W-1:3*DW]),
        .i_last  (q_rdata[QW-1]),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_index (b_index),
        .o_rgb   (b_rgb),
        .o_last  (m_tlast)
    );

    // result packing, index in the low bits
    assign m_tdata = {b_rgb, b_index};

endmodule
